// ----- rtl/core/apg_pkg.sv -----
`timescale 1ns / 1ps
package apg_pkg;

    // coordinate format
    localparam int CW  = 32;          // coordinate width
    localparam int FB  = 8;           // fraction bits
    localparam int TB  = 16;          // trig fraction bits
    localparam int DW  = 16;          // distance register width
    localparam int FRW = 12;          // fill ratio width

    // direction path
    localparam int MW  = CW + 1;      // |tip - from|
    localparam int PSW = $clog2(MW);  // leading one position
    localparam int NW  = 31;          // normalised magnitude, top bit at NW-1
    localparam int SW  = 2 * NW + 1;  // sum of squares
    localparam int RW  = 64;          // square root working width
    localparam int LW  = 32;          // root width
    localparam int QW  = TB + 1;      // trig magnitude
    localparam int QSW = QW + 1;      // signed trig
    localparam int NUW = NW + TB + 1; // divider numerator
    localparam int RMW = NUW + 1;     // divider remainder

    // head geometry
    localparam int PRW = DW * 2;      // line_width * length
    localparam int LFW = DW + FRW;    // length * fill ratio
    localparam int VW  = LFW - FB;    // widest distance operand
    localparam int BKW = DW + 1;      // backup
    localparam int MPW = VW + QW;     // distance * trig
    localparam int RDW = MPW - TB;    // rounded product magnitude
    localparam int SGW = RDW + 1;     // rounded product, signed
    localparam int EW  = CW + 2;      // sums before clamping

    // divide by ten: ceil(2^23 / 10), exact below 2^22
    localparam int              D10_SH  = 23;
    localparam logic [VW-1:0]   D10_MUL = VW'(838861);

    // pipeline depths
    localparam int NORM_LAT = 5;
    localparam int SQRT_LAT = LW;
    localparam int DIV_LAT  = QW;
    localparam int TRIG_LAT = SQRT_LAT + DIV_LAT + 1;
    localparam int GEOM_LAT = 4;
    localparam int SIDE_LAT = NORM_LAT + TRIG_LAT;
    localparam int PIPE_LAT = SIDE_LAT + GEOM_LAT;

    // register map
    localparam int IXW = 3;
    localparam logic [IXW-1:0] REG_ENABLED   = 3'd0;
    localparam logic [IXW-1:0] REG_LINE_W    = 3'd1;
    localparam logic [IXW-1:0] REG_ARROW_LEN = 3'd2;
    localparam logic [IXW-1:0] REG_ARROW_W   = 3'd3;
    localparam logic [IXW-1:0] REG_FILL      = 3'd4;
    localparam logic [IXW-1:0] REG_CAP       = 3'd5;

    typedef struct packed {
        logic signed [CW-1:0] tip_x;
        logic signed [CW-1:0] tip_y;
        logic signed [CW-1:0] from_x;
        logic signed [CW-1:0] from_y;
        logic                 pull_back;
    } t_in;

    typedef struct packed {
        logic signed [CW-1:0] base_x;
        logic signed [CW-1:0] base_y;
        logic                 base_valid;
        logic signed [CW-1:0] left_x;
        logic signed [CW-1:0] left_y;
        logic signed [CW-1:0] right_x;
        logic signed [CW-1:0] right_y;
        logic signed [CW-1:0] line_end_x;
        logic signed [CW-1:0] line_end_y;
        logic                 saturated;
    } t_out;

    typedef struct packed {
        logic           enabled;
        logic [DW-1:0]  line_width;
        logic [DW-1:0]  arrow_length;
        logic [DW-1:0]  arrow_width;
        logic [FRW-1:0] fill_ratio;
        logic           cap_projecting;
    } t_cfg;

    typedef struct packed {
        logic [DW-1:0]  len;
        logic [DW-1:0]  w;
        logic [VW-1:0]  flen;
        logic [BKW-1:0] backup;
        logic           has_base;
    } t_dist;

    typedef struct packed {
        logic signed [CW-1:0] tip_x;
        logic signed [CW-1:0] tip_y;
        logic                 pull;
    } t_side;

    typedef struct packed {
        logic [NW-1:0] nx;
        logic [NW-1:0] ny;
        logic [SW-1:0] sum;
        logic          neg_x;
        logic          neg_y;
        logic          zero;
    } t_norm;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [RW-1:0] root;
    } t_sq;

    typedef struct packed {
        logic [RMW-1:0] rx;
        logic [RMW-1:0] ry;
        logic [QW-1:0]  qx;
        logic [QW-1:0]  qy;
    } t_dv;

    typedef struct packed {
        logic signed [QSW-1:0] c;
        logic signed [QSW-1:0] s;
    } t_trig;

endpackage

// ----- rtl/core/apg_cfg.sv -----
`timescale 1ns / 1ps
// Free-running derivation of head distances from the registers.
module apg_cfg (
    input  logic          i_clk,
    input  apg_pkg::t_cfg i_cfg,
    output apg_pkg::t_dist o_dist
);
    import apg_pkg::*;

    localparam int QN = DW;

    logic [DW-1:0]  r_w;
    logic [PRW-1:0] r_prod;
    logic [PRW-1:0] r_rem [0:QN-1];
    logic [QN-1:0]  r_q   [0:QN-1];
    logic [DW-1:0]  r_mins;
    logic [VW-1:0]  r_x11;
    logic [DW-1:0]  r_mins2;
    logic [2*VW-1:0] r_mul;
    logic [DW-1:0]  r_mins3;
    t_dist          r_dist;

    logic [DW-1:0]  n_w;
    logic [LFW-1:0] n_lenfr;
    logic [VW-1:0]  n_flen;
    logic [BKW-1:0] n_backup;
    logic           n_has_base;

    function automatic logic [PRW+QN-1:0] f_step(logic [PRW-1:0] rem, logic [QN-1:0] q,
                                                  logic [DW-1:0] d, int j);
        logic [PRW-1:0] dd;
        dd = PRW'(d) << (QN - 1 - j);
        if (rem >= dd) begin
            return {rem - dd, q | (QN'(1) << (QN - 1 - j))};
        end
        return {rem, q};
    endfunction

    assign n_w = (i_cfg.arrow_width < i_cfg.line_width) ? i_cfg.line_width : i_cfg.arrow_width;

    always_ff @(posedge i_clk) begin
        r_w    <= n_w;
        r_prod <= i_cfg.line_width * i_cfg.arrow_length;
        {r_rem[0], r_q[0]} <= f_step(r_prod, '0, r_w, 0);
    end

    for (genvar j = 1; j < QN; j++) begin : g_div
        always_ff @(posedge i_clk) begin
            {r_rem[j], r_q[j]} <= f_step(r_rem[j-1], r_q[j-1], r_w, j);
        end
    end

    always_ff @(posedge i_clk) begin
        r_mins  <= (r_w == '0) ? '0 : r_q[QN-1];
        r_x11   <= VW'(r_mins) * VW'(11);
        r_mins2 <= r_mins;
        r_mul   <= r_x11 * D10_MUL;
        r_mins3 <= r_mins2;
        r_dist  <= {i_cfg.arrow_length, r_w, n_flen, n_backup, n_has_base};
    end

    always_comb begin
        n_lenfr    = i_cfg.arrow_length * i_cfg.fill_ratio;
        n_has_base = (i_cfg.fill_ratio != '0) && (i_cfg.arrow_length != '0);
        if ((i_cfg.fill_ratio != '0) && (n_lenfr < (LFW'(r_mins3) << FB))) begin
            n_flen = VW'(r_mul[2*VW-1:D10_SH]);
        end else begin
            n_flen = n_lenfr[FB +: VW];
        end
        n_backup = '0;
        if (i_cfg.line_width > DW'(1 << FB)) begin
            if (i_cfg.cap_projecting) begin
                n_backup = BKW'(i_cfg.line_width >> 1);
            end
            if (n_has_base && (r_w != '0)) begin
                n_backup = n_backup + BKW'(r_mins3 >> 1);
            end
        end
    end

    assign o_dist = r_dist;

endmodule

// ----- rtl/core/apg_norm.sv -----
`timescale 1ns / 1ps
// Direction magnitudes, normalisation and sum of squares.
module apg_norm (
    input  logic          i_clk,
    input  logic          i_en,
    input  apg_pkg::t_in  i_word,
    output apg_pkg::t_norm o_norm
);
    import apg_pkg::*;

    logic [MW-1:0]  r_mx1, r_my1, r_mx2, r_my2;
    logic [PSW-1:0] r_pos;
    logic [NW-1:0]  r_nx3, r_ny3, r_nx4, r_ny4;
    logic [2*NW-1:0] r_sqx, r_sqy;
    logic [4:1]     r_negx, r_negy;
    logic [4:2]     r_zero;
    t_norm          r_out;

    logic signed [MW-1:0] n_dx, n_dy;
    logic [MW-1:0]        n_sx, n_sy;

    function automatic logic [PSW-1:0] f_lead(logic [MW-1:0] v);
        logic [PSW-1:0] p;
        p = '0;
        for (int i = 0; i < MW; i++) begin
            if (v[i]) begin
                p = PSW'(i);
            end
        end
        return p;
    endfunction

    assign n_dx = $signed({i_word.tip_x[CW-1], i_word.tip_x})
                - $signed({i_word.from_x[CW-1], i_word.from_x});
    assign n_dy = $signed({i_word.tip_y[CW-1], i_word.tip_y})
                - $signed({i_word.from_y[CW-1], i_word.from_y});

    always_comb begin
        if (r_pos >= PSW'(NW - 1)) begin
            n_sx = r_mx2 >> (r_pos - PSW'(NW - 1));
            n_sy = r_my2 >> (r_pos - PSW'(NW - 1));
        end else begin
            n_sx = r_mx2 << (PSW'(NW - 1) - r_pos);
            n_sy = r_my2 << (PSW'(NW - 1) - r_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx1 <= n_dx[MW-1] ? MW'(-n_dx) : MW'(n_dx);
            r_my1 <= n_dy[MW-1] ? MW'(-n_dy) : MW'(n_dy);
            r_negx[1] <= n_dx[MW-1];
            r_negy[1] <= n_dy[MW-1];

            r_mx2 <= r_mx1;
            r_my2 <= r_my1;
            r_pos <= f_lead(r_mx1 | r_my1);
            r_zero[2] <= (r_mx1 | r_my1) == '0;

            r_nx3 <= n_sx[NW-1:0];
            r_ny3 <= n_sy[NW-1:0];

            r_sqx <= r_nx3 * r_nx3;
            r_sqy <= r_ny3 * r_ny3;
            r_nx4 <= r_nx3;
            r_ny4 <= r_ny3;

            for (int k = 2; k <= 4; k++) begin
                r_negx[k] <= r_negx[k-1];
                r_negy[k] <= r_negy[k-1];
            end
            for (int k = 3; k <= 4; k++) begin
                r_zero[k] <= r_zero[k-1];
            end

            r_out <= {r_nx4, r_ny4, SW'(r_sqx) + SW'(r_sqy), r_negx[4], r_negy[4], r_zero[4]};
        end
    end

    assign o_norm = r_out;

endmodule

// ----- rtl/core/apg_trig.sv -----
`timescale 1ns / 1ps
// Bit-per-stage square root, then bit-per-stage divide for cos and sin.
module apg_trig (
    input  logic          i_clk,
    input  logic          i_en,
    input  apg_pkg::t_norm i_norm,
    output apg_pkg::t_trig o_trig
);
    import apg_pkg::*;

    t_sq           r_sq  [0:SQRT_LAT-1];
    t_norm         r_nrm [0:SQRT_LAT-1];
    t_dv           r_dv  [0:DIV_LAT-1];
    logic [LW-1:0] r_l   [0:DIV_LAT-1];
    logic [2:0]    r_fl  [0:DIV_LAT-1];   // neg_x, neg_y, zero
    t_trig         r_out;

    logic [RMW-1:0] n_rx0, n_ry0;
    logic [LW-1:0]  n_l0;

    function automatic t_sq f_sq(t_sq a, int k);
        logic [RW-1:0] b;
        logic [RW-1:0] t;
        t_sq           o;
        b = RW'(1) << (2 * (LW - 1) - 2 * k);
        t = a.root + b;
        if (a.rem >= t) begin
            o.rem  = a.rem - t;
            o.root = (a.root >> 1) + b;
        end else begin
            o.rem  = a.rem;
            o.root = a.root >> 1;
        end
        return o;
    endfunction

    function automatic t_dv f_dv(t_dv a, logic [LW-1:0] l, int j);
        logic [RMW-1:0] d;
        t_dv            o;
        d = RMW'(l) << (QW - 1 - j);
        o = a;
        if (a.rx >= d) begin
            o.rx = a.rx - d;
            o.qx = a.qx | (QW'(1) << (QW - 1 - j));
        end
        if (a.ry >= d) begin
            o.ry = a.ry - d;
            o.qy = a.qy | (QW'(1) << (QW - 1 - j));
        end
        return o;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq[0]  <= f_sq({RW'(i_norm.sum), RW'(0)}, 0);
            r_nrm[0] <= i_norm;
        end
    end

    for (genvar k = 1; k < SQRT_LAT; k++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[k]  <= f_sq(r_sq[k-1], k);
                r_nrm[k] <= r_nrm[k-1];
            end
        end
    end

    assign n_l0  = r_sq[SQRT_LAT-1].root[LW-1:0];
    assign n_rx0 = (RMW'(r_nrm[SQRT_LAT-1].nx) << TB) + RMW'(n_l0 >> 1);
    assign n_ry0 = (RMW'(r_nrm[SQRT_LAT-1].ny) << TB) + RMW'(n_l0 >> 1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv[0] <= f_dv({n_rx0, n_ry0, QW'(0), QW'(0)}, n_l0, 0);
            r_l[0]  <= n_l0;
            r_fl[0] <= {r_nrm[SQRT_LAT-1].neg_x, r_nrm[SQRT_LAT-1].neg_y,
                        r_nrm[SQRT_LAT-1].zero};
        end
    end

    for (genvar j = 1; j < DIV_LAT; j++) begin : g_dv
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[j] <= f_dv(r_dv[j-1], r_l[j-1], j);
                r_l[j]  <= r_l[j-1];
                r_fl[j] <= r_fl[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_fl[DIV_LAT-1][0]) begin
                r_out <= '0;
            end else begin
                r_out.c <= r_fl[DIV_LAT-1][2] ? -$signed({1'b0, r_dv[DIV_LAT-1].qx})
                                              :  $signed({1'b0, r_dv[DIV_LAT-1].qx});
                r_out.s <= r_fl[DIV_LAT-1][1] ? -$signed({1'b0, r_dv[DIV_LAT-1].qy})
                                              :  $signed({1'b0, r_dv[DIV_LAT-1].qy});
            end
        end
    end

    assign o_trig = r_out;

endmodule

// ----- rtl/core/apg_geom.sv -----
`timescale 1ns / 1ps
// Distance x trig products, rounding, point sums and clamping.
module apg_geom (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic           i_enabled,
    input  apg_pkg::t_dist i_dist,
    input  apg_pkg::t_trig i_trig,
    input  apg_pkg::t_side i_side,
    output apg_pkg::t_out  o_word
);
    import apg_pkg::*;

    localparam int NP = 8;  // len*c, len*s, flen*c, flen*s, w*s, w*c, bk*c, bk*s

    logic [MPW-1:0]        r_p   [0:NP-1];
    logic [NP-1:0]         r_pn;
    logic signed [SGW-1:0] r_r   [0:NP-1];
    logic signed [EW-1:0]  r_e   [0:7];   // base xy, left xy, right xy, end xy
    t_side                 r_sd  [1:3];
    t_out                  r_out;

    logic [QW-1:0] n_mc, n_ms;
    logic [VW-1:0] n_v  [0:NP-1];
    logic [NP-1:0] n_neg;
    logic signed [EW-1:0] n_tx, n_ty, n_p0x, n_p0y;
    t_out          n_out;
    logic          n_sat;

    function automatic logic signed [CW-1:0] f_clamp(logic signed [EW-1:0] v, output logic s);
        logic signed [EW-1:0] hi, lo;
        hi = EW'({1'b0, {(CW-1){1'b1}}});
        lo = -hi - EW'(1);
        s  = 1'b0;
        if (v > hi) begin
            s = 1'b1;
            return hi[CW-1:0];
        end
        if (v < lo) begin
            s = 1'b1;
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    assign n_mc = i_trig.c[QSW-1] ? QW'(-i_trig.c) : QW'(i_trig.c);
    assign n_ms = i_trig.s[QSW-1] ? QW'(-i_trig.s) : QW'(i_trig.s);

    always_comb begin
        n_v[0] = VW'(i_dist.len);    n_neg[0] = i_trig.c[QSW-1];
        n_v[1] = VW'(i_dist.len);    n_neg[1] = i_trig.s[QSW-1];
        n_v[2] = i_dist.flen;        n_neg[2] = i_trig.c[QSW-1];
        n_v[3] = i_dist.flen;        n_neg[3] = i_trig.s[QSW-1];
        n_v[4] = VW'(i_dist.w);      n_neg[4] = i_trig.s[QSW-1];
        n_v[5] = VW'(i_dist.w);      n_neg[5] = i_trig.c[QSW-1];
        n_v[6] = VW'(i_dist.backup); n_neg[6] = i_trig.c[QSW-1];
        n_v[7] = VW'(i_dist.backup); n_neg[7] = i_trig.s[QSW-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NP; i++) begin
                r_p[i] <= n_v[i] * (((i % 2) == 0) == (i < 4 || i >= 6) ? n_mc : n_ms);
                r_r[i] <= r_pn[i] ? -$signed({1'b0, RDW'((r_p[i] + MPW'(1 << (TB-1))) >> TB)})
                                  :  $signed({1'b0, RDW'((r_p[i] + MPW'(1 << (TB-1))) >> TB)});
            end
            r_pn     <= n_neg;
            r_sd[1]  <= i_side;
            r_sd[2]  <= r_sd[1];
            r_sd[3]  <= r_sd[2];
            r_e[0] <= n_tx - EW'(r_r[2]);
            r_e[1] <= n_ty - EW'(r_r[3]);
            r_e[2] <= n_p0x - EW'(r_r[4]);
            r_e[3] <= n_p0y + EW'(r_r[5]);
            r_e[4] <= n_p0x + EW'(r_r[4]);
            r_e[5] <= n_p0y - EW'(r_r[5]);
            r_e[6] <= r_sd[2].pull ? n_tx - EW'(r_r[6]) : n_tx;
            r_e[7] <= r_sd[2].pull ? n_ty - EW'(r_r[7]) : n_ty;
            r_out  <= n_out;
        end
    end

    assign n_tx  = EW'(r_sd[2].tip_x);
    assign n_ty  = EW'(r_sd[2].tip_y);
    assign n_p0x = n_tx - EW'(r_r[0]);
    assign n_p0y = n_ty - EW'(r_r[1]);

    always_comb begin
        logic s0, s1, s2, s3, s4, s5, s6, s7;
        n_out = '0;
        n_out.base_x     = f_clamp(r_e[0], s0);
        n_out.base_y     = f_clamp(r_e[1], s1);
        n_out.left_x     = f_clamp(r_e[2], s2);
        n_out.left_y     = f_clamp(r_e[3], s3);
        n_out.right_x    = f_clamp(r_e[4], s4);
        n_out.right_y    = f_clamp(r_e[5], s5);
        n_out.line_end_x = f_clamp(r_e[6], s6);
        n_out.line_end_y = f_clamp(r_e[7], s7);
        n_out.base_valid = i_dist.has_base;
        n_sat = s2 | s3 | s4 | s5 | s6 | s7 | (i_dist.has_base & (s0 | s1));
        if (!i_dist.has_base) begin
            n_out.base_x = '0;
            n_out.base_y = '0;
        end
        n_out.saturated = n_sat;
        if (!i_enabled) begin
            n_out            = '0;
            n_out.line_end_x = r_sd[3].tip_x;
            n_out.line_end_y = r_sd[3].tip_y;
        end
    end

    assign o_word = r_out;

endmodule

// ----- rtl/core/arrowhead_polygon_geometry_top.sv -----
`timescale 1ns / 1ps
// Channel | direction | handshake                  | word
// --------+-----------+----------------------------+------------------------------
// in      | sink      | i_in_valid / o_in_ready    | i_in_word  (apg_pkg::t_in)
// out     | source    | o_out_valid / i_out_ready  | o_out_word (apg_pkg::t_out)
// cfg     | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One word per cycle sustained while the output is not stalled; each word
// passes from acceptance to the output register through the normalise,
// square root, divide, sign and geometry stages.
// Synchronous active-low reset clears the valid bits and loads the configuration registers with their defaults.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Register writes are always taken; apg_cfg derives the distances from them.
module arrowhead_polygon_geometry_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  apg_pkg::t_in             i_in_word,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output apg_pkg::t_out            o_out_word,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [apg_pkg::IXW-1:0]  i_cfg_index,
    input  logic [apg_pkg::DW-1:0]   i_cfg_data
);
    import apg_pkg::*;

    t_cfg                r_cfg;
    logic [PIPE_LAT-1:0] r_vld;
    t_side               r_side [0:SIDE_LAT-1];

    logic  n_en;
    t_norm n_norm;
    t_trig n_trig;
    t_dist n_dist;

    // whole pipe moves unless the output word is held
    assign n_en        = !r_vld[PIPE_LAT-1] || i_out_ready;
    assign o_in_ready  = n_en;
    assign o_out_valid = r_vld[PIPE_LAT-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= {1'b0, DW'(256), DW'(2048), DW'(1024), FRW'(256), 1'b0};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ENABLED:   r_cfg.enabled        <= i_cfg_data[0];
                REG_LINE_W:    r_cfg.line_width     <= i_cfg_data;
                REG_ARROW_LEN: r_cfg.arrow_length   <= i_cfg_data;
                REG_ARROW_W:   r_cfg.arrow_width    <= i_cfg_data;
                REG_FILL:      r_cfg.fill_ratio     <= i_cfg_data[FRW-1:0];
                REG_CAP:       r_cfg.cap_projecting <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in_valid};
        end
    end

    // tip and pull flag wait here while the direction is worked out
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_side[0] <= {i_in_word.tip_x, i_in_word.tip_y, i_in_word.pull_back};
            for (int k = 1; k < SIDE_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    apg_cfg u_cfg (
        .i_clk  (i_clk),
        .i_cfg  (r_cfg),
        .o_dist (n_dist)
    );

    apg_norm u_norm (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_word (i_in_word),
        .o_norm (n_norm)
    );

    apg_trig u_trig (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_norm (n_norm),
        .o_trig (n_trig)
    );

    apg_geom u_geom (
        .i_clk     (i_clk),
        .i_en      (n_en),
        .i_enabled (r_cfg.enabled),
        .i_dist    (n_dist),
        .i_trig    (n_trig),
        .i_side    (r_side[SIDE_LAT-1]),
        .o_word    (o_out_word)
    );

endmodule
